>>> rtl/core/srd_pkg.sv
// Shared constants for the sustained rise detector.
package srd_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int VALUE_BITS_DEF = 16;
    localparam int LEVEL_BITS     = 15;
    localparam int DUR_BITS       = 32;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ON_LEVEL     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OFF_LEVEL    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_DURATION = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAP_LIMIT    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_START = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_END   = 3'd5;

    localparam logic [LEVEL_BITS-1:0] ON_LEVEL_RST     = 15'd16384;
    localparam logic [LEVEL_BITS-1:0] OFF_LEVEL_RST    = 15'd8192;
    localparam logic [DUR_BITS-1:0]   MIN_DURATION_RST = 32'd1000000;

    localparam logic [1:0] REASON_FOUND       = 2'd0;
    localparam logic [1:0] REASON_NO_VALID    = 2'd1;
    localparam logic [1:0] REASON_NO_PICKUP   = 2'd2;
    localparam logic [1:0] REASON_NEVER_LIFTED = 2'd3;

endpackage

>>> rtl/core/sustained_rise_detector.sv
// Top level of the sustained rise detector: configuration registers, front and back ends.
//
//   channel  | direction | tdata                          | tuser        | tlast
//   s_       | in        | sample_time, sample_value      | value_valid  | last_sample
//   m_       | out       | rise_found, rise_time,         | -            | -
//            |           | fail_reason, after_gap,        |              |
//            |           | truncated                      |              |
//
// The back end takes samples while idle; a request marked last leads to the emit state.
// A pickup that needs interpolation runs the serial multiply/divide unit, NW bits wide
// (NW = max(VALUE_BITS, 16)); the back end takes no samples until it is done.
// Reset is synchronous; it restores register defaults and clears all run state.
// A two-entry queue lets the input keep taking requests while the back end or the result stalls.
module sustained_rise_detector
    import srd_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IN_W  = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((TIME_BITS + 5 + 7) / 8) * 8,
    localparam int CFG_W = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_W-1:0]          s_tdata,   // sample_time, sample_value, zero fill
    input  logic                     s_tuser,   // value_valid
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata,   // rise_found, rise_time, fail_reason,
                                                // after_gap, truncated, zero fill
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_W-1:0]         cfg_wdata
);

    logic [LEVEL_BITS-1:0] on_reg, off_reg;
    logic [DUR_BITS-1:0]   min_dur_reg, gap_reg;
    logic [TIME_BITS-1:0]  win_start_reg, win_end_reg;

    logic                  q_valid, q_ready, q_vflag, q_last, q_inwin;
    logic [TIME_BITS-1:0]  q_time;
    logic [VALUE_BITS-1:0] q_value;
    logic                  r_found, r_after_gap, r_truncated;
    logic [TIME_BITS-1:0]  r_time;
    logic [1:0]            r_reason;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg        <= ON_LEVEL_RST;
            off_reg       <= OFF_LEVEL_RST;
            min_dur_reg   <= MIN_DURATION_RST;
            gap_reg       <= '0;
            win_start_reg <= '0;
            win_end_reg   <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ON_LEVEL:     on_reg        <= cfg_wdata[LEVEL_BITS-1:0];
                REG_OFF_LEVEL:    off_reg       <= cfg_wdata[LEVEL_BITS-1:0];
                REG_MIN_DURATION: min_dur_reg   <= cfg_wdata[DUR_BITS-1:0];
                REG_GAP_LIMIT:    gap_reg       <= cfg_wdata[DUR_BITS-1:0];
                REG_WINDOW_START: win_start_reg <= cfg_wdata[TIME_BITS-1:0];
                REG_WINDOW_END:   win_end_reg   <= cfg_wdata[TIME_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    srd_front #(
        .TIME_BITS  (TIME_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_time      (s_tdata[TIME_BITS-1:0]),
        .in_value     (s_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS]),
        .in_vflag     (s_tuser),
        .in_last      (s_tlast),
        .window_start (win_start_reg),
        .window_end   (win_end_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_time       (q_time),
        .q_value      (q_value),
        .q_vflag      (q_vflag),
        .q_last       (q_last),
        .q_inwin      (q_inwin)
    );

    srd_back #(
        .TIME_BITS  (TIME_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_time       (q_time),
        .q_value      (q_value),
        .q_vflag      (q_vflag),
        .q_last       (q_last),
        .q_inwin      (q_inwin),
        .on_level     (on_reg),
        .off_level    (off_reg),
        .min_duration (min_dur_reg),
        .gap_limit    (gap_reg),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_found      (r_found),
        .m_time       (r_time),
        .m_reason     (r_reason),
        .m_after_gap  (r_after_gap),
        .m_truncated  (r_truncated)
    );

    assign m_tdata = OUT_W'({r_truncated, r_after_gap, r_reason, r_time, r_found});

endmodule

>>> rtl/core/srd_front.sv
// Front end: window classification and a short request queue.
module srd_front
    import srd_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_BITS-1:0]  in_time,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  in_vflag,
    input  logic                  in_last,
    input  logic [TIME_BITS-1:0]  window_start,
    input  logic [TIME_BITS-1:0]  window_end,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [TIME_BITS-1:0]  q_time,
    output logic [VALUE_BITS-1:0] q_value,
    output logic                  q_vflag,
    output logic                  q_last,
    output logic                  q_inwin
);

    localparam int EW = TIME_BITS + VALUE_BITS + 3;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [EW-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop, inwin;
    logic [EW-1:0] head;

    assign inwin    = (in_time >= window_start) && (in_time <= window_end);
    assign in_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign head     = mem_reg[rd_ptr_reg];
    assign {q_last, q_vflag, q_inwin, q_value, q_time} = head;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= {in_last, in_vflag, inwin, in_value, in_time};
        end
    end

endmodule

>>> rtl/core/srd_interp.sv
// Serial shift-add multiply and restoring divide for the rise start interpolation.
module srd_interp
    import srd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int NUM_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] base,
    input  logic [TIME_BITS-1:0] dt,
    input  logic [NUM_BITS-1:0]  num,
    input  logic [NUM_BITS-1:0]  den,
    output logic                 done,
    output logic [TIME_BITS-1:0] result
);

    localparam int PW = TIME_BITS + NUM_BITS;
    localparam int KW = $clog2(PW + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [KW-1:0]        cnt_reg, cnt_next;
    logic [PW-1:0]        acc_reg, acc_next, mcand_reg, mcand_next;
    logic [NUM_BITS-1:0]  mplier_reg, mplier_next, den_reg, den_next;
    logic [NUM_BITS-1:0]  rem_reg, rem_next;
    logic [TIME_BITS-1:0] base_reg, base_next;
    logic [NUM_BITS:0]    trial;

    assign trial  = {rem_reg, acc_reg[PW-1]};
    assign done   = (state_reg == ST_DONE);
    assign result = base_reg + acc_reg[TIME_BITS-1:0];

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        base_next   = base_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    acc_next    = '0;
                    mcand_next  = PW'(dt);
                    mplier_next = num;
                    den_next    = den;
                    base_next   = base;
                    cnt_next    = KW'(NUM_BITS);
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == KW'(1)) begin
                    rem_next   = '0;
                    cnt_next   = KW'(PW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = NUM_BITS'(trial - {1'b0, den_reg});
                    acc_next = {acc_reg[PW-2:0], 1'b1};
                end else begin
                    rem_next = trial[NUM_BITS-1:0];
                    acc_next = {acc_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == KW'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
    end

endmodule

>>> rtl/core/srd_back.sv
// Back end: rise tracking state machine, interpolation and result register.
module srd_back
    import srd_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [TIME_BITS-1:0]  q_time,
    input  logic [VALUE_BITS-1:0] q_value,
    input  logic                  q_vflag,
    input  logic                  q_last,
    input  logic                  q_inwin,
    input  logic [LEVEL_BITS-1:0] on_level,
    input  logic [LEVEL_BITS-1:0] off_level,
    input  logic [DUR_BITS-1:0]   min_duration,
    input  logic [DUR_BITS-1:0]   gap_limit,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [TIME_BITS-1:0]  m_time,
    output logic [1:0]            m_reason,
    output logic                  m_after_gap,
    output logic                  m_truncated
);

    localparam int NW = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    localparam int CW = NW + 1;
    localparam int DW = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic lifted_reg, lifted_next, rising_reg, rising_next, fg_reg, fg_next;
    logic contig_reg, contig_next, have_reg, have_next, any_reg, any_next;
    logic done_reg, done_next, rag_reg, rag_next, lastp_reg, lastp_next;
    logic [TIME_BITS-1:0]  prev_t_reg, prev_t_next, start_reg, start_next;
    logic [VALUE_BITS-1:0] prev_v_reg, prev_v_next;
    logic m_valid_reg, m_valid_next, m_found_reg, m_found_next;
    logic [TIME_BITS-1:0] m_time_reg, m_time_next;
    logic [1:0] m_reason_reg, m_reason_next;
    logic m_gap_reg, m_gap_next, m_trunc_reg, m_trunc_next;

    logic signed [CW-1:0] v_ext, pv_ext, on_ext, off_ext;
    logic [TIME_BITS-1:0] div_dt, div_result;
    logic [NW-1:0]        div_num, div_den;
    logic                 div_start, div_done, gap, skip, found;

    function automatic logic lasted_f(input logic [TIME_BITS-1:0] to_t,
                                      input logic [TIME_BITS-1:0] from_t,
                                      input logic [DUR_BITS-1:0]  md);
        logic [DW-1:0] d;
        d = DW'(to_t - from_t);
        return (to_t >= from_t) && (d >= DW'(md));
    endfunction

    assign v_ext   = $signed({{(CW-VALUE_BITS){q_value[VALUE_BITS-1]}}, q_value});
    assign pv_ext  = $signed({{(CW-VALUE_BITS){prev_v_reg[VALUE_BITS-1]}}, prev_v_reg});
    assign on_ext  = $signed({{(CW-LEVEL_BITS){1'b0}}, on_level});
    assign off_ext = $signed({{(CW-LEVEL_BITS){1'b0}}, off_level});
    assign gap     = have_reg && (gap_limit != '0) && (q_time >= prev_t_reg)
                     && (DW'(q_time - prev_t_reg) > DW'(gap_limit));
    assign div_dt  = (q_time >= prev_t_reg) ? q_time - prev_t_reg : '0;
    assign div_num = NW'(on_ext - pv_ext);
    assign div_den = NW'(v_ext - pv_ext);
    assign found   = done_reg || rising_reg;

    assign q_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_time      = m_time_reg;
    assign m_reason    = m_reason_reg;
    assign m_after_gap = m_gap_reg;
    assign m_truncated = m_trunc_reg;

    srd_interp #(
        .TIME_BITS (TIME_BITS),
        .NUM_BITS  (NW)
    ) u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .base    (prev_t_reg),
        .dt      (div_dt),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .result  (div_result)
    );

    always_comb begin
        state_next    = state_reg;
        lifted_next   = lifted_reg;
        rising_next   = rising_reg;
        fg_next       = fg_reg;
        contig_next   = contig_reg;
        have_next     = have_reg;
        any_next      = any_reg;
        done_next     = done_reg;
        rag_next      = rag_reg;
        lastp_next    = lastp_reg;
        prev_t_next   = prev_t_reg;
        prev_v_next   = prev_v_reg;
        start_next    = start_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_found_next  = m_found_reg;
        m_time_next   = m_time_reg;
        m_reason_next = m_reason_reg;
        m_gap_next    = m_gap_reg;
        m_trunc_next  = m_trunc_reg;
        div_start     = 1'b0;
        skip          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (!done_reg && q_inwin) begin
                        if (!q_vflag || gap) begin
                            if (rising_reg && lasted_f(prev_t_reg, start_reg, min_duration)) begin
                                done_next = 1'b1;
                                skip      = 1'b1;
                            end else begin
                                rising_next = 1'b0;
                                fg_next     = 1'b1;
                                contig_next = 1'b0;
                                if (!q_vflag) begin
                                    have_next = 1'b0;
                                    skip      = 1'b1;
                                end
                            end
                        end
                        if (!skip) begin
                            any_next = 1'b1;
                            if (!rising_next) begin
                                if (!lifted_reg) begin
                                    if (v_ext <= off_ext) begin
                                        lifted_next = 1'b1;
                                    end
                                end else if (v_ext >= on_ext) begin
                                    rising_next = 1'b1;
                                    rag_next    = fg_next;
                                    if (contig_next && (pv_ext < on_ext)) begin
                                        div_start = 1'b1;
                                    end else begin
                                        start_next = q_time;
                                    end
                                end
                            end else if (v_ext < off_ext) begin
                                if (lasted_f(q_time, start_reg, min_duration)) begin
                                    done_next = 1'b1;
                                    skip      = 1'b1;
                                end else begin
                                    rising_next = 1'b0;
                                end
                            end
                        end
                        if (!skip) begin
                            have_next   = 1'b1;
                            contig_next = 1'b1;
                            fg_next     = 1'b0;
                            prev_t_next = q_time;
                            prev_v_next = q_value;
                        end
                    end
                    if (div_start) begin
                        lastp_next = q_last;
                        state_next = ST_CALC;
                    end else if (q_last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CALC: begin
                if (div_done) begin
                    start_next = div_result;
                    state_next = lastp_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = found;
                    m_time_next   = found ? start_reg : '0;
                    m_gap_next    = found && rag_reg;
                    m_trunc_next  = found && !done_reg
                                    && !lasted_f(prev_t_reg, start_reg, min_duration);
                    if (found) begin
                        m_reason_next = REASON_FOUND;
                    end else if (!any_reg) begin
                        m_reason_next = REASON_NO_VALID;
                    end else if (lifted_reg) begin
                        m_reason_next = REASON_NO_PICKUP;
                    end else begin
                        m_reason_next = REASON_NEVER_LIFTED;
                    end
                    lifted_next = 1'b0;
                    rising_next = 1'b0;
                    fg_next     = 1'b0;
                    contig_next = 1'b0;
                    have_next   = 1'b0;
                    any_next    = 1'b0;
                    done_next   = 1'b0;
                    rag_next    = 1'b0;
                    prev_t_next = '0;
                    prev_v_next = '0;
                    start_next  = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lifted_reg  <= 1'b0;
            rising_reg  <= 1'b0;
            fg_reg      <= 1'b0;
            contig_reg  <= 1'b0;
            have_reg    <= 1'b0;
            any_reg     <= 1'b0;
            done_reg    <= 1'b0;
            rag_reg     <= 1'b0;
            lastp_reg   <= 1'b0;
            prev_t_reg  <= '0;
            prev_v_reg  <= '0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lifted_reg  <= lifted_next;
            rising_reg  <= rising_next;
            fg_reg      <= fg_next;
            contig_reg  <= contig_next;
            have_reg    <= have_next;
            any_reg     <= any_next;
            done_reg    <= done_next;
            rag_reg     <= rag_next;
            lastp_reg   <= lastp_next;
            prev_t_reg  <= prev_t_next;
            prev_v_reg  <= prev_v_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        m_found_reg  <= m_found_next;
        m_time_reg   <= m_time_next;
        m_reason_reg <= m_reason_next;
        m_gap_reg    <= m_gap_next;
        m_trunc_reg  <= m_trunc_next;
    end

endmodule
